/* hw/rtl/gia_pkg.sv */
`timescale 1ns / 1ps

package gia_pkg;

    localparam int MAX_ENTITIES = 1024;
    localparam int GEN_BITS     = 8;
    localparam int MAX_BURST    = 64;

    localparam int IDX_W   = $clog2(MAX_ENTITIES);
    localparam int DEPTH_W = $clog2(MAX_ENTITIES + 1);
    localparam int AVAIL_W = DEPTH_W + 1;
    localparam int COUNT_W = 7;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_STK_ADDR,
        S_STK_DATA,
        S_STK_EMIT,
        S_FRESH,
        S_FULL,
        S_FREE_RD,
        S_FREE_WR
    } t_state;

    typedef enum logic [1:0] {
        SRC_STACK,
        SRC_FRESH,
        SRC_FULL
    } t_out_src;

    typedef struct packed {
        logic     capture;
        logic     start_alloc;
        logic     clear;
        logic     gen_rd_free;
        logic     free_commit;
        logic     push;
        t_out_src out_src;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              cnt_zero;
        logic              burst_full;
        logic              stk_some;
        logic              free_ok;
        logic              stk_last;
        logic              all_last;
        logic              out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/gia_datapath.sv */
`timescale 1ns / 1ps

module gia_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gia_pkg::t_dp_cmd                i_cmd,
    output gia_pkg::t_dp_sts                o_sts,
    input  logic [gia_pkg::MODE_W-1:0]      i_mode,
    input  logic [gia_pkg::COUNT_W-1:0]     i_count,
    input  logic [gia_pkg::IDX_W-1:0]       i_free_index,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [gia_pkg::IDX_W-1:0]       o_new_index,
    output logic [gia_pkg::GEN_BITS-1:0]    o_generation,
    output logic                            o_full_res,
    output logic                            o_last
);

    localparam logic [gia_pkg::AVAIL_W-1:0] MaxAvail = gia_pkg::AVAIL_W'(gia_pkg::MAX_ENTITIES);
    localparam logic [gia_pkg::DEPTH_W-1:0] MaxDepth = gia_pkg::DEPTH_W'(gia_pkg::MAX_ENTITIES);
    localparam logic [gia_pkg::COUNT_W-1:0] MaxBurst = gia_pkg::COUNT_W'(gia_pkg::MAX_BURST);
    localparam logic [gia_pkg::COUNT_W-1:0] OneCount = gia_pkg::COUNT_W'(1);

    logic [gia_pkg::MODE_W-1:0]   r_mode;
    logic [gia_pkg::COUNT_W-1:0]  r_count;
    logic [gia_pkg::IDX_W-1:0]    r_idx;
    logic [gia_pkg::DEPTH_W-1:0]  r_depth, n_depth;
    logic [gia_pkg::DEPTH_W-1:0]  r_hw, n_hw;
    logic [gia_pkg::DEPTH_W-1:0]  r_sp, n_sp;
    logic [gia_pkg::COUNT_W-1:0]  r_stk_left, n_stk_left;
    logic [gia_pkg::COUNT_W-1:0]  r_left, n_left;

    logic [gia_pkg::GEN_BITS-1:0] r_gen_mem [gia_pkg::MAX_ENTITIES];
    logic [gia_pkg::IDX_W-1:0]    r_stk_mem [gia_pkg::MAX_ENTITIES];
    logic [gia_pkg::GEN_BITS-1:0] r_gen_q;
    logic [gia_pkg::IDX_W-1:0]    r_stk_q;

    logic                         r_out_valid, n_out_valid;
    logic [gia_pkg::IDX_W-1:0]    r_out_idx;
    logic [gia_pkg::GEN_BITS-1:0] r_out_gen;
    logic                         r_out_full;
    logic                         r_out_last;

    logic [gia_pkg::AVAIL_W-1:0]  avail;
    logic [gia_pkg::DEPTH_W-1:0]  taken;
    logic [gia_pkg::DEPTH_W-1:0]  base;
    logic                         burst_full;
    logic                         out_free;
    logic                         push_stack;
    logic                         push_fresh;
    logic [gia_pkg::IDX_W-1:0]    gen_raddr;
    logic                         gen_we;
    logic [gia_pkg::IDX_W-1:0]    gen_waddr;
    logic [gia_pkg::GEN_BITS-1:0] gen_wdata;

    // capacity check and split of the burst between stack and fresh indices
    assign avail = gia_pkg::AVAIL_W'(r_depth) + (MaxAvail - gia_pkg::AVAIL_W'(r_hw));
    assign burst_full = (r_count > MaxBurst) || (gia_pkg::AVAIL_W'(r_count) > avail);
    assign taken = (gia_pkg::DEPTH_W'(r_count) < r_depth) ? gia_pkg::DEPTH_W'(r_count) : r_depth;
    assign base = r_depth - taken;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign push_stack = i_cmd.push && (i_cmd.out_src == gia_pkg::SRC_STACK);
    assign push_fresh = i_cmd.push && (i_cmd.out_src == gia_pkg::SRC_FRESH);

    assign o_sts.mode       = r_mode;
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.burst_full = burst_full;
    assign o_sts.stk_some   = (r_depth != '0);
    assign o_sts.free_ok    = (gia_pkg::DEPTH_W'(r_idx) < r_hw) && (r_depth < MaxDepth);
    assign o_sts.stk_last   = (r_stk_left == OneCount);
    assign o_sts.all_last   = (r_left == OneCount);
    assign o_sts.out_free   = out_free;

    always_comb begin
        n_depth    = r_depth;
        n_hw       = r_hw;
        n_sp       = r_sp;
        n_stk_left = r_stk_left;
        n_left     = r_left;
        if (i_cmd.clear) begin
            n_depth = '0;
            n_hw    = '0;
        end
        if (i_cmd.start_alloc) begin
            n_depth    = base;
            n_sp       = base;
            n_stk_left = gia_pkg::COUNT_W'(taken);
            n_left     = r_count;
        end
        if (i_cmd.free_commit) begin
            n_depth = r_depth + 1'b1;
        end
        if (push_stack) begin
            n_sp       = r_sp + 1'b1;
            n_stk_left = r_stk_left - 1'b1;
            n_left     = r_left - 1'b1;
        end
        if (push_fresh) begin
            n_hw   = r_hw + 1'b1;
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_hw    <= '0;
        end else begin
            r_depth <= n_depth;
            r_hw    <= n_hw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_count <= i_count;
            r_idx   <= i_free_index;
        end
        r_sp       <= n_sp;
        r_stk_left <= n_stk_left;
        r_left     <= n_left;
    end

    // generation table: read every cycle, write fresh zero or incremented value
    assign gen_raddr = i_cmd.gen_rd_free ? r_idx : r_stk_q;
    assign gen_we    = i_cmd.free_commit || push_fresh;
    assign gen_waddr = i_cmd.free_commit ? r_idx : r_hw[gia_pkg::IDX_W-1:0];
    assign gen_wdata = i_cmd.free_commit ? r_gen_q + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        r_gen_q <= r_gen_mem[gen_raddr];
        if (gen_we) begin
            r_gen_mem[gen_waddr] <= gen_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stk_q <= r_stk_mem[r_sp[gia_pkg::IDX_W-1:0]];
        if (i_cmd.free_commit) begin
            r_stk_mem[r_depth[gia_pkg::IDX_W-1:0]] <= r_idx;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            case (i_cmd.out_src)
                gia_pkg::SRC_STACK: begin
                    r_out_idx  <= r_stk_q;
                    r_out_gen  <= r_gen_q;
                    r_out_full <= 1'b0;
                    r_out_last <= (r_left == OneCount);
                end
                gia_pkg::SRC_FRESH: begin
                    r_out_idx  <= r_hw[gia_pkg::IDX_W-1:0];
                    r_out_gen  <= '0;
                    r_out_full <= 1'b0;
                    r_out_last <= (r_left == OneCount);
                end
                default: begin
                    r_out_idx  <= '0;
                    r_out_gen  <= '0;
                    r_out_full <= 1'b1;
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_new_index  = r_out_idx;
    assign o_generation = r_out_gen;
    assign o_full_res   = r_out_full;
    assign o_last       = r_out_last;

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= MaxDepth)
        else $error("stack depth beyond capacity");

    a_hw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= MaxDepth)
        else $error("high-water mark beyond capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !i_cmd.push)
        else $error("pending transaction overwritten");

endmodule

/* hw/rtl/gia_ctrl.sv */
`timescale 1ns / 1ps

module gia_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gia_pkg::t_dp_sts i_sts,
    output gia_pkg::t_dp_cmd o_cmd
);

    gia_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gia_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gia_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gia_pkg::S_DECODE;
                end
            end
            gia_pkg::S_DECODE: begin
                unique case (i_sts.mode)
                    gia_pkg::MODE_ALLOC: begin
                        if (i_sts.cnt_zero) begin
                            n_state = gia_pkg::S_IDLE;
                        end else if (i_sts.burst_full) begin
                            n_state = gia_pkg::S_FULL;
                        end else if (i_sts.stk_some) begin
                            n_state = gia_pkg::S_STK_ADDR;
                        end else begin
                            n_state = gia_pkg::S_FRESH;
                        end
                    end
                    gia_pkg::MODE_FREE: begin
                        n_state = i_sts.free_ok ? gia_pkg::S_FREE_RD : gia_pkg::S_IDLE;
                    end
                    default: begin
                        n_state = gia_pkg::S_IDLE;
                    end
                endcase
            end
            gia_pkg::S_STK_ADDR: n_state = gia_pkg::S_STK_DATA;
            gia_pkg::S_STK_DATA: n_state = gia_pkg::S_STK_EMIT;
            gia_pkg::S_STK_EMIT: begin
                if (i_sts.out_free) begin
                    if (!i_sts.stk_last) begin
                        n_state = gia_pkg::S_STK_ADDR;
                    end else if (i_sts.all_last) begin
                        n_state = gia_pkg::S_IDLE;
                    end else begin
                        n_state = gia_pkg::S_FRESH;
                    end
                end
            end
            gia_pkg::S_FRESH: begin
                if (i_sts.out_free && i_sts.all_last) begin
                    n_state = gia_pkg::S_IDLE;
                end
            end
            gia_pkg::S_FULL: begin
                if (i_sts.out_free) begin
                    n_state = gia_pkg::S_IDLE;
                end
            end
            gia_pkg::S_FREE_RD: n_state = gia_pkg::S_FREE_WR;
            gia_pkg::S_FREE_WR: n_state = gia_pkg::S_IDLE;
            default:            n_state = gia_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.out_src     = gia_pkg::SRC_FULL;
        o_in_stall        = (r_state != gia_pkg::S_IDLE);
        unique case (r_state)
            gia_pkg::S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            gia_pkg::S_DECODE: begin
                o_cmd.start_alloc = (i_sts.mode == gia_pkg::MODE_ALLOC)
                                    && !i_sts.cnt_zero && !i_sts.burst_full;
                o_cmd.clear       = (i_sts.mode == gia_pkg::MODE_CLEAR);
            end
            gia_pkg::S_STK_EMIT: begin
                o_cmd.push    = i_sts.out_free;
                o_cmd.out_src = gia_pkg::SRC_STACK;
            end
            gia_pkg::S_FRESH: begin
                o_cmd.push    = i_sts.out_free;
                o_cmd.out_src = gia_pkg::SRC_FRESH;
            end
            gia_pkg::S_FULL: begin
                o_cmd.push    = i_sts.out_free;
                o_cmd.out_src = gia_pkg::SRC_FULL;
            end
            gia_pkg::S_FREE_RD: begin
                o_cmd.gen_rd_free = 1'b1;
            end
            gia_pkg::S_FREE_WR: begin
                o_cmd.gen_rd_free = 1'b1;
                o_cmd.free_commit = 1'b1;
            end
            default: begin
            end
        endcase
    end

    a_push_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_sts.out_free)
        else $error("push without room in output register");

    a_free_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gia_pkg::S_FREE_RD |=> o_cmd.free_commit)
        else $error("free read not followed by commit");

    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == gia_pkg::S_DECODE)
        else $error("captured transaction not decoded");

endmodule

/* hw/rtl/generational_id_allocator.sv */
`timescale 1ns / 1ps
// Allocate: decode, then states STK_ADDR, STK_DATA and STK_EMIT per handle taken from the free stack
// (stack read, then generation table read) and state FRESH per fresh handle; output stalls hold both.
// Free: decode plus generation read-modify-write (FREE_RD, FREE_WR); clear and no-op: decode only.
// One transaction in flight at a time; results leave through a one-deep output register.
// Reset is synchronous, active low: empties stack and high-water mark; tables are not swept.
module generational_id_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [gia_pkg::MODE_W-1:0]      i_mode,
    input  logic [gia_pkg::COUNT_W-1:0]     i_count,
    input  logic [gia_pkg::IDX_W-1:0]       i_free_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gia_pkg::IDX_W-1:0]       o_new_index,
    output logic [gia_pkg::GEN_BITS-1:0]    o_generation,
    output logic                            o_full_res,
    output logic                            o_last
);

    gia_pkg::t_dp_cmd cmd;
    gia_pkg::t_dp_sts sts;

    gia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gia_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_count      (i_count),
        .i_free_index (i_free_index),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_new_index  (o_new_index),
        .o_generation (o_generation),
        .o_full_res   (o_full_res),
        .o_last       (o_last)
    );

endmodule
